/* rtl/rfa_pkg.sv */
// ----------------------------------------------------------------------------
// rfa_pkg: shared types and constants of the region feature accumulator
// Widths, command codes, the request and region-entry records, and the
// state encoding of the back end.
// ----------------------------------------------------------------------------
package rfa_pkg;

    localparam int MAX_REGIONS   = 1024;
    localparam int COORD_BITS    = 12;
    localparam int FRACTION_BITS = 8;

    localparam int ADDR_W  = $clog2(MAX_REGIONS);
    localparam int LABEL_W = $clog2(MAX_REGIONS + 1);
    localparam int AREA_W  = 2 * COORD_BITS + 1;
    localparam int SUM_W   = AREA_W + COORD_BITS - 1;
    localparam int CENT_W  = COORD_BITS + FRACTION_BITS;
    localparam int DVD_W   = SUM_W + FRACTION_BITS;
    localparam int PADDR_W = 4;

    localparam logic [AREA_W-1:0] AREA_CAP = AREA_W'(1) << (2 * COORD_BITS);
    localparam logic [LABEL_W-1:0] LABEL_TOP = LABEL_W'(MAX_REGIONS);

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ACC   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_e;

    typedef enum logic [1:0] {
        REG_ROW_FIRST = 2'd0,
        REG_ROW_LAST  = 2'd1,
        REG_COL_FIRST = 2'd2,
        REG_COL_LAST  = 2'd3
    } reg_e;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ACC   = 2'd1,
        OP_READ  = 2'd2
    } op_e;

    typedef enum logic [2:0] {
        B_SWEEP,
        B_IDLE,
        B_ACC,
        B_READ,
        B_DIV,
        B_OUT
    } back_state_e;

    typedef struct packed {
        logic [COORD_BITS-1:0] row_first;
        logic [COORD_BITS-1:0] row_last;
        logic [COORD_BITS-1:0] col_first;
        logic [COORD_BITS-1:0] col_last;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        row_first: '0,
        row_last:  '1,
        col_first: '0,
        col_last:  '1
    };

    typedef struct packed {
        op_e                   op;
        logic                  hit;
        logic [ADDR_W-1:0]     addr;
        logic [LABEL_W-1:0]    label;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
    } req_t;

    typedef struct packed {
        logic [AREA_W-1:0]     area;
        logic [SUM_W-1:0]      sum_x;
        logic [SUM_W-1:0]      sum_y;
        logic [COORD_BITS-1:0] x_min;
        logic [COORD_BITS-1:0] x_max;
        logic [COORD_BITS-1:0] y_min;
        logic [COORD_BITS-1:0] y_max;
    } entry_t;

    typedef struct packed {
        logic [LABEL_W-1:0]    region_id;
        logic [AREA_W-1:0]     area;
        logic [CENT_W-1:0]     centroid_x;
        logic [CENT_W-1:0]     centroid_y;
        logic [COORD_BITS-1:0] box_x_min;
        logic [COORD_BITS-1:0] box_x_max;
        logic [COORD_BITS-1:0] box_y_min;
        logic [COORD_BITS-1:0] box_y_max;
    } rsp_t;

    typedef struct packed {
        logic push;
        logic full;
    } q_ctl_t;

endpackage

/* rtl/rfa_front.sv */
// ----------------------------------------------------------------------------
// rfa_front: request intake and classification
// Decodes the command, checks the label range and the window, and hands
// only requests with an effect to the queue.
// ----------------------------------------------------------------------------
module rfa_front
(
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [1:0]                     command,
    input  logic [rfa_pkg::LABEL_W-1:0]    label,
    input  logic [rfa_pkg::COORD_BITS-1:0] row,
    input  logic [rfa_pkg::COORD_BITS-1:0] column,
    input  rfa_pkg::cfg_t                  cfg,
    input  logic                           init_busy,
    input  logic                           q_full,
    output logic                           q_push,
    output rfa_pkg::req_t                  q_req
);

    logic label_ok;
    logic in_window;
    logic keep;

    assign label_ok  = (label != '0) && (label <= rfa_pkg::LABEL_TOP);
    assign in_window = (row >= cfg.row_first) && (row <= cfg.row_last) &&
                       (column >= cfg.col_first) && (column <= cfg.col_last);

    // Stall while the queue is full and during the memory clearing pass after reset.
    assign req_stall = q_full || init_busy;

    always_comb
    begin
        q_req       = '0;
        q_req.hit   = label_ok;
        q_req.addr  = rfa_pkg::ADDR_W'(label - rfa_pkg::LABEL_W'(1));
        q_req.label = label;
        q_req.row   = row;
        q_req.col   = column;
        keep        = 1'b0;
        case (rfa_pkg::cmd_e'(command))
            rfa_pkg::CMD_CLEAR:
            begin
                q_req.op = rfa_pkg::OP_CLEAR;
                keep     = 1'b1;
            end
            rfa_pkg::CMD_ACC:
            begin
                q_req.op = rfa_pkg::OP_ACC;
                keep     = label_ok && in_window;
            end
            rfa_pkg::CMD_READ:
            begin
                q_req.op = rfa_pkg::OP_READ;
                keep     = 1'b1;
            end
            default:
            begin
                q_req.op = rfa_pkg::OP_ACC;
                keep     = 1'b0;
            end
        endcase
    end

    assign q_push = req_valid && !req_stall && keep;

endmodule

/* rtl/rfa_queue.sv */
// ----------------------------------------------------------------------------
// rfa_queue: request queue between front and back
// A four-entry first-in first-out store of classified requests.
// ----------------------------------------------------------------------------
module rfa_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rfa_pkg::req_t push_req,
    input  logic          pop,
    output rfa_pkg::req_t head_req,
    output logic          empty,
    output logic          full
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    rfa_pkg::req_t      slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (PTR_W+1)'(DEPTH));
    assign head_req = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

/* rtl/rfa_div.sv */
// ----------------------------------------------------------------------------
// rfa_div: iterative centroid divider
// Restoring division, one quotient bit per cycle, for a quotient known to
// fit in the centroid width.
// ----------------------------------------------------------------------------
module rfa_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [rfa_pkg::DVD_W-1:0]       dividend,
    input  logic [rfa_pkg::AREA_W-1:0]      divisor,
    output logic [rfa_pkg::CENT_W-1:0]      quotient,
    output logic                            done
);

    localparam int AW    = rfa_pkg::AREA_W;
    localparam int QW    = rfa_pkg::CENT_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic [AW-1:0]    rem_reg, rem_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic [AW-1:0]    dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [AW:0]      trial;
    logic [AW:0]      diff;
    logic             ge;

    assign trial    = {rem_reg, quo_reg[QW-1]};
    assign diff     = trial - {1'b0, dsr_reg};
    assign ge       = trial >= {1'b0, dsr_reg};
    assign quotient = quo_reg;
    assign done     = done_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // The upper dividend bits stay below the divisor, as the quotient fits.
            rem_next  = AW'(dividend[rfa_pkg::DVD_W-1:QW]);
            quo_next  = dividend[QW-1:0];
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[AW-1:0] : trial[AW-1:0];
            quo_next = {quo_reg[QW-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

endmodule

/* rtl/rfa_back.sv */
// ----------------------------------------------------------------------------
// rfa_back: region store and request execution
// Holds the per-region statistics in one memory, sweeps it on reset and on
// clear, updates it per pixel and answers reads through the dividers.
// ----------------------------------------------------------------------------
module rfa_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  rfa_pkg::cfg_t cfg,
    input  logic          q_empty,
    input  rfa_pkg::req_t q_head,
    output logic          q_pop,
    output logic          init_busy,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rfa_pkg::rsp_t rsp
);

    localparam int AW = rfa_pkg::ADDR_W;

    rfa_pkg::entry_t     mem [rfa_pkg::MAX_REGIONS];
    rfa_pkg::entry_t     rdata_reg;
    rfa_pkg::entry_t     wr_data;
    rfa_pkg::entry_t     upd;
    logic                rd_en;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;

    rfa_pkg::back_state_e state_reg, state_next;
    logic [AW-1:0]       sweep_reg, sweep_next;
    logic                init_busy_reg, init_busy_next;
    rfa_pkg::req_t       cur_reg, cur_next;
    rfa_pkg::cfg_t       clr_reg, clr_next;
    rfa_pkg::rsp_t       rsp_reg, rsp_next;

    logic                div_start;
    logic [rfa_pkg::DVD_W-1:0]  dvd_x, dvd_y;
    logic [rfa_pkg::CENT_W-1:0] quo_x, quo_y;
    logic                div_done_x, div_done_y;
    logic                found;

    assign dvd_x = rfa_pkg::DVD_W'(rdata_reg.sum_x) << rfa_pkg::FRACTION_BITS;
    assign dvd_y = rfa_pkg::DVD_W'(rdata_reg.sum_y) << rfa_pkg::FRACTION_BITS;

    rfa_div u_div_x
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_x),
        .divisor  (rdata_reg.area),
        .quotient (quo_x),
        .done     (div_done_x)
    );

    rfa_div u_div_y
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_y),
        .divisor  (rdata_reg.area),
        .quotient (quo_y),
        .done     (div_done_y)
    );

    // Pixel update of the entry read in the previous cycle.
    always_comb
    begin
        upd       = rdata_reg;
        upd.area  = rdata_reg.area + rfa_pkg::AREA_W'(1);
        upd.sum_x = rdata_reg.sum_x + rfa_pkg::SUM_W'(cur_reg.col);
        upd.sum_y = rdata_reg.sum_y + rfa_pkg::SUM_W'(cur_reg.row);
        if (cur_reg.col < rdata_reg.x_min)
        begin
            upd.x_min = cur_reg.col;
        end
        if (cur_reg.col > rdata_reg.x_max)
        begin
            upd.x_max = cur_reg.col;
        end
        if (cur_reg.row < rdata_reg.y_min)
        begin
            upd.y_min = cur_reg.row;
        end
        if (cur_reg.row > rdata_reg.y_max)
        begin
            upd.y_max = cur_reg.row;
        end
    end

    assign found = cur_reg.hit && (rdata_reg.area != '0);

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        init_busy_next = init_busy_reg;
        cur_next       = cur_reg;
        clr_next       = clr_reg;
        rsp_next       = rsp_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = cur_reg.addr;
        wr_data        = upd;
        div_start      = 1'b0;
        case (state_reg)
            rfa_pkg::B_SWEEP:
            begin
                wr_en         = 1'b1;
                wr_addr       = sweep_reg;
                wr_data       = '0;
                wr_data.x_min = clr_reg.col_last;
                wr_data.x_max = clr_reg.col_first;
                wr_data.y_min = clr_reg.row_last;
                wr_data.y_max = clr_reg.row_first;
                sweep_next    = sweep_reg + AW'(1);
                if (sweep_reg == AW'(rfa_pkg::MAX_REGIONS - 1))
                begin
                    init_busy_next = 1'b0;
                    state_next     = rfa_pkg::B_IDLE;
                end
            end
            rfa_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    rd_en    = 1'b1;
                    cur_next = q_head;
                    case (q_head.op)
                        rfa_pkg::OP_CLEAR:
                        begin
                            clr_next   = cfg;
                            sweep_next = '0;
                            state_next = rfa_pkg::B_SWEEP;
                        end
                        rfa_pkg::OP_ACC:  state_next = rfa_pkg::B_ACC;
                        rfa_pkg::OP_READ: state_next = rfa_pkg::B_READ;
                        default:          state_next = rfa_pkg::B_IDLE;
                    endcase
                end
            end
            rfa_pkg::B_ACC:
            begin
                // Beyond the area ceiling the pixel is dropped.
                wr_en      = (rdata_reg.area < rfa_pkg::AREA_CAP);
                state_next = rfa_pkg::B_IDLE;
            end
            rfa_pkg::B_READ:
            begin
                if (found)
                begin
                    rsp_next.region_id = cur_reg.label;
                    rsp_next.area      = rdata_reg.area;
                    rsp_next.box_x_min = rdata_reg.x_min;
                    rsp_next.box_x_max = rdata_reg.x_max;
                    rsp_next.box_y_min = rdata_reg.y_min;
                    rsp_next.box_y_max = rdata_reg.y_max;
                    div_start          = 1'b1;
                    state_next         = rfa_pkg::B_DIV;
                end
                else
                begin
                    rsp_next           = '0;
                    rsp_next.box_x_min = cfg.col_last;
                    rsp_next.box_x_max = cfg.col_first;
                    rsp_next.box_y_min = cfg.row_last;
                    rsp_next.box_y_max = cfg.row_first;
                    state_next         = rfa_pkg::B_OUT;
                end
            end
            rfa_pkg::B_DIV:
            begin
                if (div_done_x)
                begin
                    rsp_next.centroid_x = quo_x;
                    rsp_next.centroid_y = quo_y;
                    state_next          = rfa_pkg::B_OUT;
                end
            end
            rfa_pkg::B_OUT:
            begin
                if (!rsp_stall)
                begin
                    state_next = rfa_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = rfa_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rfa_pkg::B_SWEEP;
            sweep_reg     <= '0;
            init_busy_reg <= 1'b1;
            clr_reg       <= rfa_pkg::CFG_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            init_busy_reg <= init_busy_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[q_head.addr];
        end
    end

    assign init_busy = init_busy_reg;
    assign rsp_valid = (state_reg == rfa_pkg::B_OUT);
    assign rsp       = rsp_reg;

    a_init_only_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy_reg |-> state_reg == rfa_pkg::B_SWEEP)
        else $error("initial clearing pass left before it finished");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done_x |-> state_reg == rfa_pkg::B_DIV && div_done_y)
        else $error("divider finished outside the divide state");

    a_id_has_area: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_reg.region_id != '0 |-> rsp_reg.area != '0)
        else $error("nonzero region id returned with zero area");

    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rfa_pkg::B_SWEEP && sweep_reg == AW'(rfa_pkg::MAX_REGIONS - 1)
        |=> state_reg == rfa_pkg::B_IDLE && !init_busy_reg)
        else $error("clearing pass did not end after the last entry");

endmodule

/* rtl/region_feature_accumulator_unit.sv */
// ----------------------------------------------------------------------------
// region_feature_accumulator_unit: per-region statistics of a labelled image
// Accumulates area, coordinate sums and bounding box for each label and
// answers read requests with area, box and fixed-point centroid.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_valid/req_stall with command, label, row and
// column; a request is taken at a clock edge with req_valid high and req_stall
// low. Only read requests produce a response, on rsp_valid/rsp_stall, taken at
// an edge with rsp_valid high and rsp_stall low. The window registers must be
// written through the APB port only while the block is idle; the block itself
// does not enforce this. A classifying front end drops pixels that lie outside
// the window or carry an unusable label, and queues the rest in a four-entry
// queue, so requests keep being taken, until the queue is full, while the back
// end works or a response waits on rsp_stall. The back end and its single-port
// region memory set the pace: a pixel is read, then written back; a read of a
// nonempty region waits on the bit-serial dividers (20 quotient bits) and on
// rsp_stall; a read of an empty region skips the dividers. The back end takes
// the next request from the queue only once it is through with the last one.
// A clear request sweeps the 1024-entry memory, one entry per cycle. After
// reset the same sweep runs with the reset window values; req_stall stays
// high until it is done. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module region_feature_accumulator_unit
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rfa_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,

    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [1:0]                     command,
    input  logic [rfa_pkg::LABEL_W-1:0]    label,
    input  logic [rfa_pkg::COORD_BITS-1:0] row,
    input  logic [rfa_pkg::COORD_BITS-1:0] column,

    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [rfa_pkg::LABEL_W-1:0]    region_id,
    output logic [rfa_pkg::AREA_W-1:0]     area,
    output logic [rfa_pkg::CENT_W-1:0]     centroid_x,
    output logic [rfa_pkg::CENT_W-1:0]     centroid_y,
    output logic [rfa_pkg::COORD_BITS-1:0] box_x_min,
    output logic [rfa_pkg::COORD_BITS-1:0] box_x_max,
    output logic [rfa_pkg::COORD_BITS-1:0] box_y_min,
    output logic [rfa_pkg::COORD_BITS-1:0] box_y_max
);

    rfa_pkg::cfg_t  cfg_reg, cfg_next;
    rfa_pkg::reg_e  reg_sel;
    rfa_pkg::q_ctl_t q_ctl;
    rfa_pkg::req_t  push_req;
    rfa_pkg::req_t  head_req;
    rfa_pkg::rsp_t  rsp;
    logic           q_empty;
    logic           q_pop;
    logic           init_busy;
    logic           cfg_wr;
    logic [rfa_pkg::COORD_BITS-1:0] wval;

    // Register file: the word address picks the register, byte offset ignored.
    assign pready  = 1'b1;
    assign reg_sel = rfa_pkg::reg_e'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign wval    = pwdata[rfa_pkg::COORD_BITS-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        case (reg_sel)
            rfa_pkg::REG_ROW_FIRST:
            begin
                prdata = 32'(cfg_reg.row_first);
                if (cfg_wr)
                begin
                    cfg_next.row_first = wval;
                end
            end
            rfa_pkg::REG_ROW_LAST:
            begin
                prdata = 32'(cfg_reg.row_last);
                if (cfg_wr)
                begin
                    cfg_next.row_last = wval;
                end
            end
            rfa_pkg::REG_COL_FIRST:
            begin
                prdata = 32'(cfg_reg.col_first);
                if (cfg_wr)
                begin
                    cfg_next.col_first = wval;
                end
            end
            rfa_pkg::REG_COL_LAST:
            begin
                prdata = 32'(cfg_reg.col_last);
                if (cfg_wr)
                begin
                    cfg_next.col_last = wval;
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= rfa_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: classification and intake.
    rfa_front u_front
    (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .command   (command),
        .label     (label),
        .row       (row),
        .column    (column),
        .cfg       (cfg_reg),
        .init_busy (init_busy),
        .q_full    (q_ctl.full),
        .q_push    (q_ctl.push),
        .q_req     (push_req)
    );

    // Queue decouples intake from execution.
    rfa_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_ctl.push),
        .push_req (push_req),
        .pop      (q_pop),
        .head_req (head_req),
        .empty    (q_empty),
        .full     (q_ctl.full)
    );

    // Back end: region memory, updates and read responses.
    rfa_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_head    (head_req),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    assign region_id  = rsp.region_id;
    assign area       = rsp.area;
    assign centroid_x = rsp.centroid_x;
    assign centroid_y = rsp.centroid_y;
    assign box_x_min  = rsp.box_x_min;
    assign box_x_max  = rsp.box_x_max;
    assign box_y_min  = rsp.box_y_min;
    assign box_y_max  = rsp.box_y_max;

endmodule
